// File: src/tcce_pkg.sv
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Geometry, field layouts, operation codes and the tab width table shared by
// the console sequencer, its address unit and the top level.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // Screen geometry
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 4;
  localparam int CELLS    = COLUMNS * ROWS;

  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int TAB_W  = $clog2(TAB_STOP + 1);

  // Character codes
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BLANK   = 8'h00;

  localparam logic [7:0] RESET_COLOR = 8'h07;

  // Operation codes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Register file
  localparam int         PADDR_W           = 3;
  localparam logic [0:0] REG_DEFAULT_COLOR = 1'b0;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [6:0] read_col;
    logic [4:0] read_row;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_pos;
    logic [7:0]  cell_char;
    logic [7:0]  cell_color;
  } out_item_t;

  // Write request towards the character and colour stores; reads share addr
  typedef struct packed {
    logic              char_we;
    logic              color_we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        char_wd;
    logic [7:0]        color_wd;
  } mem_req_t;

  // Spaces a tab emits from each column, fixed when the tab arrives
  typedef logic [TAB_W-1:0] tab_tbl_t [2**COL_W];

  function automatic tab_tbl_t build_tab();
    tab_tbl_t tbl;
    for (int i = 0; i < 2**COL_W; i++) begin
      tbl[i] = TAB_W'(TAB_STOP - (i % TAB_STOP));
    end
    return tbl;
  endfunction

  localparam tab_tbl_t TAB_SPACES = build_tab();

endpackage

// File: src/tcce_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/tcce_addr_unit.sv
// ----------------------------------------------------------------------------
// Console address unit
// Maps a row and column to a linear cell index. With rotate set, the row is
// first offset by the scroll base, so the store behaves as a ring of rows.
// ----------------------------------------------------------------------------
module tcce_addr_unit (
  input  logic [tcce_pkg::ROW_W-1:0]  row,
  input  logic [tcce_pkg::COL_W-1:0]  col,
  input  logic                        rotate,
  input  logic [tcce_pkg::ROW_W-1:0]  base,
  output logic [tcce_pkg::ADDR_W-1:0] lin
);

  import tcce_pkg::*;

  logic [ROW_W:0]   row_sum;
  logic [ROW_W-1:0] phys_row;

  always_comb begin
    row_sum = {1'b0, row} + (rotate ? {1'b0, base} : '0);
    // wrap once round the ring
    if (row_sum >= (ROW_W + 1)'(ROWS)) begin
      phys_row = ROW_W'(row_sum - (ROW_W + 1)'(ROWS));
    end else begin
      phys_row = ROW_W'(row_sum);
    end
    lin = ADDR_W'(phys_row * ADDR_W'(COLUMNS)) + ADDR_W'(col);
  end

endmodule

// File: src/tcce_seq.sv
// ----------------------------------------------------------------------------
// Console sequencer
// Interprets one command at a time: writes characters, reads cells, moves the cursor,
// walks the cell counter through the reset sweep, clears and bottom-row blanking on scroll.
// ----------------------------------------------------------------------------
module tcce_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  tcce_pkg::in_item_t    item,
  output logic                  done,
  output tcce_pkg::out_item_t   result,
  input  logic [7:0]            fill_color,
  output tcce_pkg::mem_req_t    mem_req,
  input  logic [7:0]            rd_char_q,
  input  logic [7:0]            rd_color_q
);

  import tcce_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_PUT    = 7'b0000100,
    S_SCROLL = 7'b0001000,
    S_SWEEP  = 7'b0010000,
    S_READ   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t            state;
  state_t            ret_state;
  in_item_t          cmd;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ROW_W-1:0]  base;
  logic [ADDR_W-1:0] sweep_addr;
  logic [ADDR_W-1:0] sweep_last;
  logic [7:0]        sweep_color;
  logic [TAB_W-1:0]  tab_left;
  logic [7:0]        put_char;
  logic [7:0]        rd_char;
  logic [7:0]        rd_color;

  logic [ROW_W-1:0]  au_row;
  logic [COL_W-1:0]  au_col;
  logic              au_rotate;
  logic [ADDR_W-1:0] au_lin;

  logic              col_last;
  logic              row_last;
  logic              read_ok;

  tcce_addr_unit u_addr (
    .row    (au_row),
    .col    (au_col),
    .rotate (au_rotate),
    .base   (base),
    .lin    (au_lin)
  );

  assign busy     = (state != S_IDLE);
  assign col_last = (cur_col == COL_W'(COLUMNS - 1));
  assign row_last = (cur_row == ROW_W'(ROWS - 1));
  assign read_ok  = ({1'b0, cmd.read_col} < 8'(COLUMNS)) &&
                    ({2'b0, cmd.read_row} < 7'(ROWS));

  // Address unit input selection
  always_comb begin
    au_row    = cur_row;
    au_col    = cur_col;
    au_rotate = 1'b1;
    case (state)
      S_EXEC: begin
        au_row = ROW_W'(cmd.read_row);
        au_col = COL_W'(cmd.read_col);
      end
      S_PUT: begin
        au_rotate = 1'b1;
      end
      S_SCROLL: begin
        au_row = '0;
        au_col = '0;
      end
      default: begin
        au_rotate = 1'b0;
      end
    endcase
  end

  always_comb begin
    mem_req          = '0;
    mem_req.addr     = au_lin;
    mem_req.char_wd  = put_char;
    mem_req.color_wd = sweep_color;
    case (state)
      S_PUT: begin
        mem_req.char_we = 1'b1;
      end
      S_SWEEP: begin
        mem_req.addr     = sweep_addr;
        mem_req.char_we  = 1'b1;
        mem_req.color_we = 1'b1;
        mem_req.char_wd  = CH_BLANK;
      end
      default: begin
        mem_req.char_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      ret_state   <= S_IDLE;
      sweep_addr  <= '0;
      sweep_last  <= ADDR_W'(CELLS - 1);
      sweep_color <= RESET_COLOR;
      cur_col     <= '0;
      cur_row     <= '0;
      base        <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd      <= item;
            rd_char  <= '0;
            rd_color <= '0;
            state    <= S_EXEC;
          end
        end

        S_EXEC: begin
          state <= S_DONE;
          if (cmd.operation == OP_PUT) begin
            if (cmd.char_code == CH_NEWLINE) begin
              cur_col <= '0;
              if (row_last) begin
                ret_state <= S_DONE;
                state     <= S_SCROLL;
              end else begin
                cur_row <= cur_row + 1'b1;
              end
            end else if (cmd.char_code == CH_RETURN) begin
              cur_col <= '0;
            end else if (cmd.char_code == CH_TAB) begin
              tab_left <= TAB_SPACES[cur_col];
              put_char <= CH_SPACE;
              state    <= S_PUT;
            end else begin
              tab_left <= TAB_W'(1);
              put_char <= cmd.char_code;
              state    <= S_PUT;
            end
          end else if (cmd.operation == OP_READ) begin
            // read issued this cycle, data lands next cycle
            if (read_ok) begin
              state <= S_READ;
            end
          end else if (cmd.operation == OP_CLEAR) begin
            cur_col     <= '0;
            cur_row     <= '0;
            base        <= '0;
            sweep_addr  <= '0;
            sweep_last  <= ADDR_W'(CELLS - 1);
            sweep_color <= fill_color;
            ret_state   <= S_DONE;
            state       <= S_SWEEP;
          end
        end

        S_PUT: begin
          tab_left <= tab_left - 1'b1;
          if (col_last) begin
            cur_col <= '0;
            if (!row_last) begin
              cur_row <= cur_row + 1'b1;
            end
          end else begin
            cur_col <= cur_col + 1'b1;
          end
          if (col_last && row_last) begin
            ret_state <= (tab_left != TAB_W'(1)) ? S_PUT : S_DONE;
            state     <= S_SCROLL;
          end else if (tab_left == TAB_W'(1)) begin
            state <= S_DONE;
          end
        end

        S_SCROLL: begin
          // old top physical row becomes the blank bottom row
          sweep_addr  <= au_lin;
          sweep_last  <= au_lin + ADDR_W'(COLUMNS - 1);
          sweep_color <= fill_color;
          base        <= (base == ROW_W'(ROWS - 1)) ? '0 : base + 1'b1;
          state       <= S_SWEEP;
        end

        S_SWEEP: begin
          if (sweep_addr == sweep_last) begin
            state <= ret_state;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end

        S_READ: begin
          rd_char  <= rd_char_q;
          rd_color <= rd_color_q;
          state    <= S_DONE;
        end

        S_DONE: begin
          result.cursor_col <= 7'(cur_col);
          result.cursor_row <= 5'(cur_row);
          result.cursor_pos <= 11'(au_lin);
          result.cell_char  <= rd_char;
          result.cell_color <= rd_color;
          done              <= 1'b1;
          state             <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/text_console_cursor_engine_top.sv
// ----------------------------------------------------------------------------
// Text console cursor engine
// Teletype console over an 80 x 25 cell store with a colour register.
// Ordinary characters and in-range reads take an extra store access step; a tab
// writes one space per cell up to the next tab stop; each scroll also blanks the
// bottom row, and a clear sweeps every cell of the store.
// Throughput: one command at a time; busy is low again in the strobe cycle.
// Reset: the cell store is swept with busy high.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  tcce_pkg::in_item_t           item,
  output logic                         done,
  output tcce_pkg::out_item_t          result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tcce_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  import tcce_pkg::*;

  logic [7:0] fill_color;
  mem_req_t   mem_req;
  logic [7:0] rd_char_q;
  logic [7:0] rd_color_q;
  logic       reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1] == REG_DEFAULT_COLOR);
  assign prdata  = reg_hit ? {24'b0, fill_color} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_color <= RESET_COLOR;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      fill_color <= pwdata[7:0];
    end
  end

  tcce_ram #(.WIDTH(8), .DEPTH(CELLS)) u_char_ram (
    .clk   (clk),
    .we    (mem_req.char_we),
    .waddr (mem_req.addr),
    .wdata (mem_req.char_wd),
    .raddr (mem_req.addr),
    .rdata (rd_char_q)
  );

  tcce_ram #(.WIDTH(8), .DEPTH(CELLS)) u_color_ram (
    .clk   (clk),
    .we    (mem_req.color_we),
    .waddr (mem_req.addr),
    .wdata (mem_req.color_wd),
    .raddr (mem_req.addr),
    .rdata (rd_color_q)
  );

  tcce_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .done       (done),
    .result     (result),
    .fill_color (fill_color),
    .mem_req    (mem_req),
    .rd_char_q  (rd_char_q),
    .rd_color_q (rd_color_q)
  );

endmodule
